[hdl/ymr_pkg.sv]
`timescale 1ns / 1ps
package ymr_pkg;

    localparam int MaxPayloadDef = 1024;
    localparam int SizeDigitsDef = 8;

    localparam logic [7:0] C_SOH    = 8'h01;
    localparam logic [7:0] C_STX    = 8'h02;
    localparam logic [7:0] C_EOT    = 8'h04;
    localparam logic [7:0] C_ETB    = 8'h17;
    localparam logic [7:0] C_ACK    = 8'h06;
    localparam logic [7:0] C_NAK    = 8'h15;
    localparam logic [7:0] C_CAN    = 8'h18;
    localparam logic [7:0] C_PROMPT = 8'h43;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [26:0] UNKNOWN_LENGTH = 27'hFFFFFF;
    localparam logic [26:0] LENGTH_MAX = 27'h7FFFFFF;
    localparam logic [4:0] RETRY_LIMIT = 5'd16;

    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_REPLY_TO = 2'd1;
    localparam logic [1:0] REG_PURGE_TO = 2'd2;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_FINISHED = 2'd1;
    localparam logic [1:0] ST_CANCELLED = 2'd2;
    localparam logic [1:0] ST_ABORTED = 2'd3;

    typedef enum logic [2:0] {
        PH_PROMPT, PH_HEADER, PH_PACKET, PH_PURGE_HDR, PH_PURGE_PKT, PH_DONE
    } t_phase;

    typedef enum logic [1:0] {NP_NAME, NP_SIZE, NP_END} t_name_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [9:0]  data_offset;
        logic        commit;
        logic        reject;
        logic [31:0] prog_address;
        logic [10:0] prog_count;
        logic        erase_request;
        logic [1:0]  status;
        logic        last;
    } t_out;

    // one classified request: up to four results
    typedef struct packed {
        logic [2:0] count_m1;
        t_out [3:0] res;
    } t_bundle;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            x = x[15] ? ({x[14:0], 1'b0} ^ CRC_POLY) : {x[14:0], 1'b0};
        end
        return x;
    endfunction

endpackage

[hdl/ymr_front.sv]
`timescale 1ns / 1ps
module ymr_front
    import ymr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MaxPayloadDef,
    parameter int SIZE_DIGITS = SizeDigitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_push,
    output t_bundle     o_bundle,
    input  logic        i_full
);

    localparam logic [10:0] LongLen = 11'(MAX_PAYLOAD);
    localparam logic [10:0] ShortLen = 11'd128;

    t_phase r_phase, n_phase;
    logic [10:0] r_pos, n_pos;
    logic r_long, n_long;
    logic [7:0] r_exp, n_exp, r_rnum, n_rnum;
    logic r_num_ok, n_num_ok, r_erased, n_erased;
    logic [7:0] r_pend, n_pend;
    logic [15:0] r_crc, n_crc;
    t_name_phase r_np, n_np;
    logic [3:0] r_digits, n_digits;
    logic [26:0] r_accum, n_accum, r_flen, n_flen, r_done, n_done;
    logic [31:0] r_fptr, n_fptr, r_reply_to, r_purge_to;
    logic [4:0] r_retries, n_retries;
    logic [31:0] r_ticks, n_ticks;

    t_out    res [4];
    logic [2:0] nres;
    logic [1:0] stat;
    logic    take;

    assign o_in_ready = !i_full;
    assign take = i_in_valid && !i_full;

    always_comb begin
        logic [10:0] plen, cnt;
        logic [26:0] rem;
        logic [7:0] b;
        logic [30:0] acc;
        logic ok, purge, adv;
        logic [4:0] rl;
        n_phase = r_phase; n_pos = r_pos; n_long = r_long; n_exp = r_exp;
        n_rnum = r_rnum; n_num_ok = r_num_ok; n_erased = r_erased; n_pend = r_pend;
        n_crc = r_crc; n_np = r_np; n_digits = r_digits; n_accum = r_accum;
        n_flen = r_flen; n_done = r_done; n_fptr = r_fptr; n_retries = r_retries;
        n_ticks = r_ticks;
        for (int k = 0; k < 4; k++) res[k] = '0;
        nres = 3'd0; stat = ST_RUN; purge = 1'b0; adv = 1'b0;
        b = i_in.rx_byte;
        plen = r_long ? LongLen : ShortLen;
        cnt = '0; rem = '0; acc = '0; ok = 1'b0; rl = '0;
        // prompt owed after reset: send it, then treat as a header wait
        if (r_phase == PH_PROMPT) begin
            res[0].tx_valid = 1'b1; res[0].tx_byte = r_pend; nres = 3'd1;
            n_phase = PH_HEADER; n_ticks = '0;
        end
        if (r_phase == PH_DONE) begin
            nres = 3'd0;
        end else if (i_in.op) begin
            n_ticks = n_ticks + 32'd1;
            if (n_phase == PH_HEADER) begin
                if (n_ticks >= r_reply_to) begin
                    n_ticks = '0;
                    if (r_pend != 8'd0) begin
                        res[nres[1:0]].tx_valid = 1'b1;
                        res[nres[1:0]].tx_byte = r_pend;
                        nres = nres + 3'd1;
                    end
                end
            end else if (n_phase == PH_PACKET) begin
                if (n_ticks >= r_reply_to) begin
                    res[0].reject = 1'b1; nres = 3'd1;
                    n_phase = PH_PURGE_PKT; n_ticks = '0;
                end
            end else if (n_ticks >= r_purge_to) begin
                purge = 1'b1;
            end
        end else if (r_phase == PH_HEADER) begin
            if (b == C_SOH || b == C_STX) begin
                n_long = (b == C_STX); n_pos = 11'd1; n_crc = '0; n_num_ok = 1'b1;
                n_rnum = '0; n_np = NP_NAME; n_digits = '0; n_accum = '0;
                n_pend = '0; n_ticks = '0; n_phase = PH_PACKET;
            end else if (b == C_EOT || b == C_ETB) begin
                for (int k = 0; k < 4; k++) begin
                    res[k].tx_valid = 1'b1; res[k].tx_byte = C_ACK;
                end
                nres = 3'd4; stat = ST_FINISHED; n_phase = PH_DONE;
            end else if (b == C_CAN) begin
                nres = 3'd1; stat = ST_CANCELLED; n_phase = PH_DONE;
            end else begin
                n_phase = PH_PURGE_HDR; n_ticks = '0;
            end
        end else if (r_phase == PH_PACKET) begin
            n_ticks = '0;
            if (r_pos == 11'd1) begin
                n_rnum = b;
            end else if (r_pos == 11'd2) begin
                n_num_ok = (b == ~r_rnum);
            end else begin
                n_crc = crc_step(r_crc, b);
                if (r_pos <= plen + 11'd2) begin
                    res[0].data_valid = 1'b1; res[0].data_byte = b;
                    res[0].data_offset = 10'(r_pos - 11'd3); nres = 3'd1;
                    if (r_np == NP_NAME) begin
                        if (b == 8'd0) n_np = NP_SIZE;
                    end else if (r_np == NP_SIZE) begin
                        if (b >= 8'h30 && b <= 8'h39) begin
                            acc = {r_accum, 3'b0} + {3'b0, r_accum, 1'b0}
                                + 31'(b - 8'h30);
                            n_accum = (acc > 31'(LENGTH_MAX)) ? LENGTH_MAX : acc[26:0];
                            n_digits = r_digits + 4'd1;
                            if (n_digits >= 4'(SIZE_DIGITS)) n_np = NP_END;
                        end else begin
                            n_np = NP_END;
                        end
                    end
                end
            end
            if (r_pos >= plen + 11'd4) begin
                ok = r_num_ok && (r_rnum == r_exp || (!r_erased && r_rnum == 8'd0))
                    && n_crc == 16'd0;
                if (!ok) begin
                    res[0].reject = 1'b1; nres = 3'd1;
                    n_phase = PH_PURGE_PKT; n_ticks = '0;
                end else begin
                    cnt = plen;
                    if (!r_erased) begin
                        if (r_rnum == 8'd0) begin
                            n_exp = '0; cnt = '0; n_flen = r_accum; n_pend = C_PROMPT;
                        end
                        res[0].erase_request = 1'b1; n_erased = 1'b1;
                    end
                    rem = (n_flen > r_done) ? n_flen - r_done : '0;
                    if (27'(cnt) > rem) cnt = rem[10:0];
                    res[0].tx_valid = 1'b1; res[0].tx_byte = C_ACK;
                    res[0].commit = 1'b1; res[0].prog_address = r_fptr;
                    res[0].prog_count = cnt;
                    nres = 3'd1;
                    n_fptr = r_fptr + 32'(cnt);
                    n_done = r_done + 27'(cnt);
                    n_exp = n_exp + 8'd1;
                    n_retries = RETRY_LIMIT;
                    adv = 1'b1;
                end
            end else begin
                n_pos = r_pos + 11'd1;
            end
        end else begin
            n_ticks = '0;
        end
        if (purge) begin
            res[nres[1:0]].tx_valid = 1'b1; res[nres[1:0]].tx_byte = C_NAK;
            nres = nres + 3'd1;
            adv = 1'b1;
            if (n_phase == PH_PURGE_PKT) begin
                rl = r_retries - 5'd1;
                n_retries = rl;
                if (rl == 5'd0) begin
                    for (int k = 1; k < 4; k++) begin
                        res[k].tx_valid = 1'b1; res[k].tx_byte = C_CAN;
                    end
                    nres = 3'd4; stat = ST_ABORTED; n_phase = PH_DONE; adv = 1'b0;
                end
            end
        end
        if (adv) begin
            n_phase = PH_HEADER; n_ticks = '0;
            if (n_pend != 8'd0) begin
                res[nres[1:0]].tx_valid = 1'b1; res[nres[1:0]].tx_byte = n_pend;
                nres = nres + 3'd1;
            end
        end
        for (int k = 0; k < 4; k++) begin
            res[k].status = stat;
            res[k].last = (3'(k) == nres - 3'd1);
        end
    end

    assign o_push = take && nres != 3'd0;
    always_comb begin
        o_bundle.count_m1 = nres - 3'd1;
        for (int k = 0; k < 4; k++) o_bundle.res[k] = res[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PROMPT; r_pos <= '0; r_long <= 1'b0; r_exp <= 8'd1;
            r_rnum <= '0; r_num_ok <= 1'b1; r_erased <= 1'b0; r_pend <= C_PROMPT;
            r_crc <= '0; r_np <= NP_NAME; r_digits <= '0; r_accum <= '0;
            r_flen <= UNKNOWN_LENGTH; r_done <= '0; r_fptr <= '0;
            r_retries <= RETRY_LIMIT; r_ticks <= '0;
            r_reply_to <= 32'd30000000; r_purge_to <= 32'd10000000;
        end else begin
            if (take) begin
                r_phase <= n_phase; r_pos <= n_pos; r_long <= n_long; r_exp <= n_exp;
                r_rnum <= n_rnum; r_num_ok <= n_num_ok; r_erased <= n_erased;
                r_pend <= n_pend; r_crc <= n_crc; r_np <= n_np; r_digits <= n_digits;
                r_accum <= n_accum; r_flen <= n_flen; r_done <= n_done;
                r_retries <= n_retries; r_ticks <= n_ticks;
            end
            // base address moves the flash pointer only before the first commit
            if (i_cfg_valid && i_cfg_index == REG_BASE && !r_erased) begin
                r_fptr <= i_cfg_data;
            end else if (take) begin
                r_fptr <= n_fptr;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_REPLY_TO: r_reply_to <= i_cfg_data;
                    REG_PURGE_TO: r_purge_to <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_bundle.count_m1 <= 3'd3))
        else $error("bundle count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> !o_push)
        else $error("result after end of transfer");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase == PH_PACKET && !i_in.op) |=> (r_ticks == 32'd0))
        else $error("tick count not cleared on packet byte");

endmodule

[hdl/ymr_back.sv]
`timescale 1ns / 1ps
module ymr_back
    import ymr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out
);

    // two-entry queue of bundles, drained one result at a time
    t_bundle r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [1:0] r_sub;
    logic pop, fin;

    assign o_full = (r_cnt == 2'd2);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out = r_q[r_rp].res[r_sub];
    assign pop = o_out_valid && i_out_ready;
    assign fin = pop && ({1'b0, r_sub} == r_q[r_rp].count_m1);

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0; r_sub <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop) r_sub <= fin ? 2'd0 : r_sub + 2'd1;
            if (fin) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, fin};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && o_full))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |-> o_out.last)
        else $error("last flag mismatch");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_sub == 2'd0))
        else $error("sub index stuck");

endmodule

[hdl/ymodem_packet_receiver_top.sv]
`timescale 1ns / 1ps
// Results of a request are registered in the two-entry queue, which
// absorbs bursts. Throughput: one request per cycle unless the queue
// is full; a request with n results holds the output until all leave.
// Reset: synchronous active low; state returns to the owed prompt,
// registers to their defaults, the queue empties.
module ymodem_packet_receiver_top
    import ymr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MaxPayloadDef,
    parameter int SIZE_DIGITS = SizeDigitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out
);

    logic push, full;
    t_bundle bundle;

    assign o_cfg_ready = 1'b1;

    ymr_front #(.MAX_PAYLOAD(MAX_PAYLOAD), .SIZE_DIGITS(SIZE_DIGITS)) u_front (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in,
        .i_cfg_valid, .i_cfg_index, .i_cfg_data,
        .o_push(push), .o_bundle(bundle), .i_full(full)
    );

    ymr_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(bundle), .o_full(full),
        .o_out_valid, .i_out_ready, .o_out
    );

endmodule
